@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, held off during reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wnm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wnm_pkg
// Shared types, constants and NFA helper functions of the wildcard matcher.
// ---------------------------------------------------------------------------
package wnm_pkg;

    localparam int PATTERN_CHARS = 32;
    localparam int POS_W         = PATTERN_CHARS + 1;
    localparam int LEN_W         = 6;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int WORD_BYTES    = CFG_W / 8;
    localparam int CLOSE_LEVELS  = $clog2(POS_W);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] STAR_BYTE   = 8'h2A;
    localparam logic [7:0] PLUS_BYTE   = 8'h40;
    localparam logic [7:0] UPPER_FIRST = 8'h41;
    localparam logic [7:0] UPPER_LAST  = 8'h5A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT0 = 3'd0,
        REG_PAT1 = 3'd1,
        REG_PAT2 = 3'd2,
        REG_PAT3 = 3'd3,
        REG_LEN  = 3'd4
    } cfg_reg_t;

    typedef logic [PATTERN_CHARS-1:0] pos_mask_t;
    typedef logic [POS_W-1:0]         act_t;

    // Pattern configuration as seen by the front and the back.
    typedef struct packed {
        logic [PATTERN_CHARS*8-1:0] pattern;
        logic [LEN_W-1:0]           len;
        pos_mask_t                  star;
        act_t                       start;
        logic                       restart;
    } pat_cfg_t;

    // One classified item on its way from front to back.
    typedef struct packed {
        logic      last;
        pos_mask_t stay;
        pos_mask_t adv;
    } step_t;

    typedef struct packed {
        logic              full;
        logic              valid;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    function automatic logic [LEN_W-1:0] used_len(logic [LEN_W-1:0] len);
        if (len > LEN_W'(PATTERN_CHARS))
            return LEN_W'(PATTERN_CHARS);
        return len;
    endfunction

    function automatic logic nonupper(logic [7:0] b);
        return !((b >= UPPER_FIRST) && (b <= UPPER_LAST));
    endfunction

    function automatic pos_mask_t star_mask(logic [PATTERN_CHARS*8-1:0] pattern,
                                            logic [LEN_W-1:0] len);
        pos_mask_t m;
        m = '0;
        for (int i = 0; i < PATTERN_CHARS; i++)
            m[i] = (LEN_W'(i) < len) && (pattern[8*i +: 8] == STAR_BYTE);
        return m;
    endfunction

    // Propagate live positions across runs of stars: a parallel prefix
    // over generate (live) and propagate (star before this position).
    function automatic act_t star_closure(act_t set, pos_mask_t star);
        act_t g;
        act_t p;
        act_t g_n;
        act_t p_n;
        g = set;
        p = {star, 1'b0};
        for (int lv = 0; lv < CLOSE_LEVELS; lv++) begin
            g_n = g;
            p_n = p;
            for (int j = 0; j < POS_W; j++) begin
                if (j >= (1 << lv)) begin
                    g_n[j] = g[j] | (p[j] & g[j - (1 << lv)]);
                    p_n[j] = p[j] & p[j - (1 << lv)];
                end
                else begin
                    p_n[j] = 1'b0;
                end
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

endpackage

@@ rtl/wnm_cfg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wnm_cfg
// Pattern register file; derives used length, star mask and start set.
// ---------------------------------------------------------------------------
module wnm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wnm_pkg::CFG_W-1:0]      cfg_data,
    output wnm_pkg::pat_cfg_t              cfg
);

    logic [3:0][wnm_pkg::CFG_W-1:0] pat_reg;
    logic [3:0][wnm_pkg::CFG_W-1:0] pat_next;
    logic [wnm_pkg::LEN_W-1:0]      len_reg;
    logic [wnm_pkg::LEN_W-1:0]      len_next;
    logic                           hit;
    logic [wnm_pkg::LEN_W-1:0]      len_used;

    always_comb
    begin
        pat_next = pat_reg;
        len_next = len_reg;
        hit      = 1'b0;
        if (cfg_write_en)
        begin
            case (cfg_index)
                wnm_pkg::REG_PAT0: begin pat_next[0] = cfg_data; hit = 1'b1; end
                wnm_pkg::REG_PAT1: begin pat_next[1] = cfg_data; hit = 1'b1; end
                wnm_pkg::REG_PAT2: begin pat_next[2] = cfg_data; hit = 1'b1; end
                wnm_pkg::REG_PAT3: begin pat_next[3] = cfg_data; hit = 1'b1; end
                wnm_pkg::REG_LEN:
                begin
                    len_next = cfg_data[wnm_pkg::LEN_W-1:0];
                    hit      = 1'b1;
                end
                default: hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            pat_reg <= pat_next;
            len_reg <= len_next;
        end
    end

    assign len_used    = wnm_pkg::used_len(len_reg);
    assign cfg.pattern = pat_reg;
    assign cfg.len     = len_used;
    assign cfg.star    = wnm_pkg::star_mask(pat_reg, len_used);
    assign cfg.start   = wnm_pkg::star_closure(wnm_pkg::POS_W'(1), cfg.star);
    assign cfg.restart = hit;

endmodule

@@ rtl/wnm_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wnm_front
// Accept name items and classify the byte against every pattern position.
// ---------------------------------------------------------------------------
module wnm_front (
    input  wnm_pkg::pat_cfg_t  cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         name_byte,
    input  logic               end_of_name,
    input  wnm_pkg::q_stat_t   q_stat,
    output logic               push,
    output wnm_pkg::step_t     entry
);

    logic pass;

    assign pass     = wnm_pkg::nonupper(name_byte);
    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    // Per position: stay on star or on '@' that takes this byte;
    // advance on '@' that takes it or on an equal literal.
    always_comb
    begin
        logic [7:0] pc;
        logic       live;
        logic       plus_ok;
        entry.last = end_of_name;
        entry.stay = '0;
        entry.adv  = '0;
        for (int i = 0; i < wnm_pkg::PATTERN_CHARS; i++)
        begin
            pc      = cfg.pattern[8*i +: 8];
            live    = wnm_pkg::LEN_W'(i) < cfg.len;
            plus_ok = (pc == wnm_pkg::PLUS_BYTE) && pass;
            entry.stay[i] = live && ((pc == wnm_pkg::STAR_BYTE) || plus_ok);
            entry.adv[i]  = live && (plus_ok ||
                            ((pc != wnm_pkg::STAR_BYTE) && (pc != wnm_pkg::PLUS_BYTE)
                             && (pc == name_byte)));
        end
    end

endmodule

@@ rtl/wnm_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wnm_queue
// Two-entry queue of classified items between front and back.
// ---------------------------------------------------------------------------
module wnm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wnm_pkg::step_t    wr_item,
    input  logic              pop,
    output wnm_pkg::step_t    rd_item,
    output wnm_pkg::q_stat_t  stat
);

    wnm_pkg::step_t                 mem [wnm_pkg::QUEUE_DEPTH];
    logic                           wr_ptr_reg;
    logic                           wr_ptr_next;
    logic                           rd_ptr_reg;
    logic                           rd_ptr_next;
    logic [wnm_pkg::QCNT_W-1:0]     count_reg;
    logic [wnm_pkg::QCNT_W-1:0]     count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + wnm_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - wnm_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd_item    = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.valid = count_reg != '0;
    assign stat.full  = count_reg == wnm_pkg::QCNT_W'(wnm_pkg::QUEUE_DEPTH);

endmodule

@@ rtl/wnm_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wnm_back
// Advance the set of live pattern positions and hold the verdict register.
// ---------------------------------------------------------------------------
module wnm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  wnm_pkg::pat_cfg_t  cfg,
    input  wnm_pkg::q_stat_t   q_stat,
    input  wnm_pkg::step_t     item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               matched
);

    wnm_pkg::act_t active_reg;
    wnm_pkg::act_t active_next;
    wnm_pkg::act_t stepped;
    logic          pend_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          matched_reg;
    logic          matched_next;

    // Hold end items while a verdict still waits; data items pass unless a restart is pending.
    assign pop = q_stat.valid && !pend_reg &&
                 (!item.last || !out_valid_reg || out_ready);

    assign stepped = {1'b0, active_reg[wnm_pkg::PATTERN_CHARS-1:0] & item.stay}
                   | {active_reg[wnm_pkg::PATTERN_CHARS-1:0] & item.adv, 1'b0};

    always_comb
    begin
        active_next    = active_reg;
        matched_next   = matched_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pend_reg)
            active_next = cfg.start;
        else if (pop)
        begin
            if (item.last)
            begin
                matched_next   = active_reg[cfg.len];
                out_valid_next = 1'b1;
                active_next    = cfg.start;
            end
            else
                active_next = wnm_pkg::star_closure(stepped, cfg.star);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= wnm_pkg::POS_W'(1);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pend_reg      <= cfg.restart;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

@@ rtl/wildcard_name_matcher_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_name_matcher_top
// Anchored whole-name wildcard matcher, one name byte per item.
// ---------------------------------------------------------------------------
// Usage:
//   Load the pattern through the write port: registers 0..3 hold pattern
//   bytes 0..31 (low byte first), register 4 the length. '*' takes any run
//   of bytes, '@' one or more bytes outside A..Z, other bytes are literal.
//   Any accepted register write restarts the current name.
//   Input channel (in_valid/in_ready): one name byte per item; an item with
//   end_of_name set closes the name, its byte is ignored.
//   Output channel (out_valid/out_ready): one matched flag per end item.
// Throughput: one item per cycle; a pending restart holds every item,
//   a waiting verdict the end items. The back end's NFA step and star
//   closure over 33 positions are combinational; out_valid is set at
//   the edge that pops the end item, after it has passed the queue.
// Stall: while a verdict waits on out_ready, data items keep flowing; the
//   next end item waits in the two-entry queue, which then backs up and
//   drops in_ready.
// Reset: empty pattern of length zero, which matches only an empty name;
//   queue and verdict register empty.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wildcard_name_matcher_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [wnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wnm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     name_byte,
    input  logic                           end_of_name,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           matched
);

    wnm_pkg::pat_cfg_t cfg;
    wnm_pkg::q_stat_t  q_stat;
    wnm_pkg::step_t    wr_item;
    wnm_pkg::step_t    rd_item;
    logic              push;
    logic              pop;

    // Pattern registers and derived masks.
    wnm_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Front: accept an item and turn its byte into stay/advance masks.
    wnm_front u_front (
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .name_byte   (name_byte),
        .end_of_name (end_of_name),
        .q_stat      (q_stat),
        .push        (push),
        .entry       (wr_item)
    );

    // Decouple front and back so either can stall on its own.
    wnm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .stat    (q_stat)
    );

    // Back: advance the live-position set, emit the verdict on end items.
    wnm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .item      (rd_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched)
    );

    // Queue never holds more than its depth.
    `ASSERT_CLK_ALWAYS(a_q_bound, (q_stat.count <= wnm_pkg::QCNT_W'(wnm_pkg::QUEUE_DEPTH)), "queue over depth")
    // Back never pops an empty queue.
    `ASSERT_CLK(a_pop_valid, (pop |-> q_stat.valid), "pop from empty queue")
    // The cycle after a register write is spent on restart, not on items.
    `ASSERT_CLK(a_restart_gap, (cfg.restart |=> !pop), "pop during restart")
    // A waiting verdict blocks the next end item.
    `ASSERT_CLK(a_end_hold, ((out_valid && !out_ready && rd_item.last) |-> !pop), "verdict overwritten")

endmodule

@@ dv/wildcard_name_matcher_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_name_matcher_top_tb
// Self-checking regression of the anchored wildcard name matcher.
// ---------------------------------------------------------------------------
// A glob predictor keeps its own copy of the pattern registers and of the
// set of live pattern positions. It steps that set on every accepted name
// byte and queues the expected verdict on every end item. A monitor pops
// the oldest verdict for each accepted result and compares it. Stimulus is
// a short directed part (empty pattern, the '@' class bounds, star runs,
// length clamp, restart on a register write, dead names), then random
// patterns with names composed to match, mutated names and noise. Both
// sides idle at random; a watchdog ends a run that stops moving.
// ---------------------------------------------------------------------------
module wildcard_name_matcher_top_tb;

    localparam int HALF_PERIOD  = 10;
    localparam int IDLE_PCT     = 13;
    localparam int DRAIN_CYCLES = 8;     // covers the queue and the back-end step, with margin
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1600;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    wnm_pkg::cfg_reg_t         cfg_index;
    logic [wnm_pkg::CFG_W-1:0] cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [7:0]                name_byte;
    logic                      end_of_name;
    logic                      out_valid;
    logic                      out_ready;
    logic                      matched;

    // Predictor state: pattern registers and the live position set.
    logic [wnm_pkg::CFG_W-1:0] pat_words [4];
    logic [wnm_pkg::LEN_W-1:0] pat_len;
    wnm_pkg::act_t             live_pos;
    logic                      expected_verdicts [$];

    logic [7:0]                name_buf [$];
    logic                      verdict_want;
    bit                        steady;
    int                        items_sent;
    int                        mismatches;
    int                        idle_cycles;

    wildcard_name_matcher_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .name_byte    (name_byte),
        .end_of_name  (end_of_name),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .matched      (matched)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Glob predictor
    // -----------------------------------------------------------------------

    // Length in use: anything above the pattern size acts as the full size.
    function automatic int active_len();
        return (pat_len > wnm_pkg::PATTERN_CHARS) ? wnm_pkg::PATTERN_CHARS : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_char(int pos);
        return pat_words[pos / wnm_pkg::WORD_BYTES][(pos % wnm_pkg::WORD_BYTES) * 8 +: 8];
    endfunction

    // Epsilon closure: a live star also makes the position after it live.
    // Walk upward so that runs of stars chain in one pass.
    function automatic wnm_pkg::act_t spread_stars(wnm_pkg::act_t set);
        int n;
        n = active_len();
        for (int i = 0; i < n; i++)
        begin
            if (set[i] && pat_char(i) == wnm_pkg::STAR_BYTE)
                set[i + 1] = 1'b1;
        end
        return set;
    endfunction

    function automatic wnm_pkg::act_t consume_byte(wnm_pkg::act_t live, logic [7:0] b);
        wnm_pkg::act_t nxt;
        int            n;
        logic [7:0]    pc;
        nxt = '0;
        n   = active_len();
        for (int i = 0; i < n; i++)
        begin
            if (live[i])
            begin
                pc = pat_char(i);
                if (pc == wnm_pkg::STAR_BYTE)
                    nxt[i] = 1'b1;
                else if (pc == wnm_pkg::PLUS_BYTE)
                begin
                    // one or more bytes outside A..Z: stay and advance
                    if (!(b >= wnm_pkg::UPPER_FIRST && b <= wnm_pkg::UPPER_LAST))
                    begin
                        nxt[i]     = 1'b1;
                        nxt[i + 1] = 1'b1;
                    end
                end
                else if (pc == b)
                    nxt[i + 1] = 1'b1;
            end
        end
        return spread_stars(nxt);
    endfunction

    function automatic wnm_pkg::act_t fresh_name();
        return spread_stars(wnm_pkg::act_t'(1));
    endfunction

    // Step the predictor on one accepted item; an end item yields a verdict
    // from the accept position and starts a new name.
    function automatic void predict_item(logic [7:0] b, logic eon);
        if (eon)
        begin
            expected_verdicts.push_back(live_pos[active_len()]);
            live_pos = fresh_name();
        end
        else
            live_pos = consume_byte(live_pos, b);
    endfunction

    // -----------------------------------------------------------------------
    // Driving
    // -----------------------------------------------------------------------

    // Send one item. Entered at a falling edge, leaves at a falling edge with
    // valid still high so that back-to-back items need no extra assignment.
    task automatic send_item(input logic [7:0] b, input logic eon);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        name_byte   <= b;
        end_of_name <= eon;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_item(b, eon);
        items_sent++;
        @(negedge clk);
    endtask

    // Send the bytes in name_buf and close the name; the end byte is noise.
    task automatic send_name();
        foreach (name_buf[i])
            send_item(name_buf[i], 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    // Hold off until every verdict is in, then let trailing data items drain.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write; the caller drops the write enable afterwards.
    task automatic write_reg(input wnm_pkg::cfg_reg_t idx,
                             input logic [wnm_pkg::CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(negedge clk);
        if (idx == wnm_pkg::REG_LEN)
            pat_len = data[wnm_pkg::LEN_W-1:0];
        else
            pat_words[idx] = data;
        live_pos = fresh_name();
    endtask

    // Write all four pattern words and the length; only call when idle.
    task automatic load_pattern(input logic [wnm_pkg::PATTERN_CHARS*8-1:0] text,
                                input logic [wnm_pkg::LEN_W-1:0] len);
        for (int w = 0; w < 4; w++)
            write_reg(wnm_pkg::cfg_reg_t'(wnm_pkg::REG_PAT0 + w),
                      text[wnm_pkg::CFG_W*w +: wnm_pkg::CFG_W]);
        write_reg(wnm_pkg::REG_LEN, wnm_pkg::CFG_W'(len));
        cfg_write_en <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Directed tests
    // -----------------------------------------------------------------------

    // Reset leaves an empty pattern: only the empty name matches.
    task automatic test_after_reset();
        name_buf.delete();
        send_name();
        name_buf = '{8'h00};
        send_name();
    endtask

    // '@' takes bytes outside A..Z, including zero and '@' itself; the
    // bounds A and Z must kill it. Bytes past the length are all ones.
    task automatic test_nonupper_class();
        logic [wnm_pkg::PATTERN_CHARS*8-1:0] text;
        text       = '1;
        text[7:0]  = wnm_pkg::PLUS_BYTE;
        wait_idle();
        load_pattern(text, wnm_pkg::LEN_W'(1));
        name_buf = '{8'h00, wnm_pkg::PLUS_BYTE, 8'h5B, 8'hFF};
        send_name();
        name_buf = '{wnm_pkg::UPPER_FIRST};
        send_name();
        name_buf = '{wnm_pkg::UPPER_LAST};
        send_name();
    endtask

    // Leading star run must close over to the literal at once.
    task automatic test_star_closure();
        logic [wnm_pkg::PATTERN_CHARS*8-1:0] text;
        text         = '0;
        text[7:0]    = wnm_pkg::STAR_BYTE;
        text[15:8]   = wnm_pkg::STAR_BYTE;
        text[23:16]  = wnm_pkg::UPPER_FIRST;
        text[31:24]  = wnm_pkg::STAR_BYTE;
        wait_idle();
        load_pattern(text, wnm_pkg::LEN_W'(4));
        name_buf = '{wnm_pkg::UPPER_FIRST};
        send_name();
    endtask

    // Length 63 acts as 32; the last position is a literal zero byte.
    task automatic test_length_clamp();
        logic [wnm_pkg::PATTERN_CHARS*8-1:0] text;
        for (int i = 0; i < wnm_pkg::PATTERN_CHARS - 1; i++)
            text[8*i +: 8] = wnm_pkg::STAR_BYTE;
        text[8*(wnm_pkg::PATTERN_CHARS-1) +: 8] = 8'h00;
        wait_idle();
        load_pattern(text, '1);
        name_buf = '{8'h00};
        send_name();
        name_buf = '{8'h01};
        send_name();
    endtask

    // A register write drops the bytes seen so far in the current name.
    task automatic test_restart_on_write();
        logic [wnm_pkg::PATTERN_CHARS*8-1:0] text;
        text       = '0;
        text[7:0]  = wnm_pkg::UPPER_FIRST;
        text[15:8] = wnm_pkg::UPPER_FIRST + 8'd1;
        wait_idle();
        load_pattern(text, wnm_pkg::LEN_W'(2));
        send_item(wnm_pkg::UPPER_FIRST, 1'b0);
        wait_idle();
        write_reg(wnm_pkg::REG_PAT3, '0);
        cfg_write_en <= 1'b0;
        name_buf = '{wnm_pkg::UPPER_FIRST, wnm_pkg::UPPER_FIRST + 8'd1};
        send_name();
        send_item(wnm_pkg::UPPER_FIRST, 1'b0);
        wait_idle();
        write_reg(wnm_pkg::REG_LEN, wnm_pkg::CFG_W'(2));
        cfg_write_en <= 1'b0;
        name_buf = '{wnm_pkg::UPPER_FIRST + 8'd1};
        send_name();
    endtask

    // Once nothing is alive, later bytes must not revive the name.
    task automatic test_dead_name();
        logic [wnm_pkg::PATTERN_CHARS*8-1:0] text;
        text      = '0;
        text[7:0] = wnm_pkg::UPPER_FIRST;
        wait_idle();
        load_pattern(text, wnm_pkg::LEN_W'(1));
        name_buf = '{wnm_pkg::UPPER_FIRST + 8'd1, wnm_pkg::UPPER_FIRST};
        send_name();
    endtask

    // -----------------------------------------------------------------------
    // Random traffic
    // -----------------------------------------------------------------------

    // Compose a name from the loaded pattern so that it matches, then
    // optionally break it with one edit.
    task automatic compose_name(input bit mutate);
        logic [7:0] pc;
        logic [7:0] b;
        int         pos;
        name_buf.delete();
        for (int i = 0; i < active_len(); i++)
        begin
            pc = pat_char(i);
            if (pc == wnm_pkg::STAR_BYTE)
                repeat ($urandom_range(0, 3)) name_buf.push_back(8'($urandom));
            else if (pc == wnm_pkg::PLUS_BYTE)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    b = 8'($urandom);
                    if (b >= wnm_pkg::UPPER_FIRST && b <= wnm_pkg::UPPER_LAST)
                        b = b ^ 8'h80;     // fold uppercase into the high half
                    name_buf.push_back(b);
                end
            end
            else
                name_buf.push_back(pc);
        end
        if (mutate)
        begin
            pos = (name_buf.size() == 0) ? 0 : $urandom_range(0, name_buf.size() - 1);
            case ($urandom_range(0, 3))
                0: if (name_buf.size() != 0) name_buf[pos] = 8'($urandom);
                1: name_buf.insert(pos, 8'($urandom));
                2: if (name_buf.size() != 0) name_buf.delete(pos);
                default: name_buf.push_back(
                             8'($urandom_range(wnm_pkg::UPPER_FIRST, wnm_pkg::UPPER_LAST)));
            endcase
        end
    endtask

    // Random pattern: mostly short, sometimes empty, full size or above it;
    // now and then a solid fill of zero or all-ones bytes.
    task automatic load_random_pattern();
        logic [wnm_pkg::PATTERN_CHARS*8-1:0] text;
        logic [wnm_pkg::LEN_W-1:0]           len;
        int                                  roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            len = '0;
        else if (roll < 20)
            len = wnm_pkg::LEN_W'(wnm_pkg::PATTERN_CHARS);
        else if (roll < 25)
            len = wnm_pkg::LEN_W'($urandom_range(wnm_pkg::PATTERN_CHARS + 1,
                                                 (1 << wnm_pkg::LEN_W) - 1));
        else
            len = wnm_pkg::LEN_W'($urandom_range(1, 8));
        roll = $urandom_range(0, 99);
        for (int i = 0; i < wnm_pkg::PATTERN_CHARS; i++)
        begin
            if (roll < 5)
                text[8*i +: 8] = 8'h00;
            else if (roll < 10)
                text[8*i +: 8] = 8'hFF;
            else if ($urandom_range(0, 99) < 25)
                text[8*i +: 8] = wnm_pkg::STAR_BYTE;
            else if ($urandom_range(0, 99) < 25)
                text[8*i +: 8] = wnm_pkg::PLUS_BYTE;
            else if ($urandom_range(0, 3) == 0)
                text[8*i +: 8] = 8'h00;
            else
                text[8*i +: 8] = 8'($urandom);
        end
        wait_idle();
        load_pattern(text, len);
    endtask

    task automatic test_random_traffic();
        int base;
        int roll;
        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            load_random_pattern();
            // one long stretch with no idling on either side
            steady = (items_sent - base >= 600) && (items_sent - base < 900);
            repeat ($urandom_range(4, 8))
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    name_buf.delete();
                    repeat ($urandom_range(0, 6)) name_buf.push_back(8'($urandom));
                end
                else
                    compose_name(roll < 35);
                send_name();
            end
        end
        steady = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Result side: random back-pressure, verdict check, watchdog
    // -----------------------------------------------------------------------

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Compare each accepted verdict with the oldest one predicted.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("matched: expected none, actual %0b", matched);
                mismatches++;
            end
            else
            begin
                verdict_want = expected_verdicts.pop_front();
                if (matched !== verdict_want)
                begin
                    $error("matched: expected %0b, actual %0b", verdict_want, matched);
                    mismatches++;
                end
            end
        end
    end

    // Drop the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $error("no item moved for %0d cycles", STALL_LIMIT);
            $display("wildcard_name_matcher_top regression: fail");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = wnm_pkg::REG_PAT0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        name_byte    = '0;
        end_of_name  = 1'b0;
        out_ready    = 1'b0;
        steady       = 1'b0;
        items_sent   = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        for (int w = 0; w < 4; w++)
            pat_words[w] = '0;
        pat_len  = '0;
        live_pos = fresh_name();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_nonupper_class();
        test_star_closure();
        test_length_clamp();
        test_restart_on_write();
        test_dead_name();
        test_random_traffic();

        // drain every verdict and anything stray
        wait_idle();
        if (mismatches == 0)
            $display("wildcard_name_matcher_top regression: pass");
        else
            $display("wildcard_name_matcher_top regression: fail");
        $finish;
    end

endmodule
